// ===== sv/circular_double_ended_queue_top_defines.svh =====
// Assertion macros shared by the circular deque RTL.
// Each macro samples on aclk and is disabled while aresetn is low.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// A condition that must hold at every sampled edge.
`define CDEQ_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define CDEQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define CDEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/cdeq_pkg.sv =====
// Package of the circular deque: command and status codes, field widths
// and stream packing constants. No dependencies.
package cdeq_pkg;

    // Default number of slots.
    localparam int DEPTH_DEF = 16;

    // Field widths.
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 3;
    localparam int STS_W     = 2;
    localparam int CNT_OUT_W = 5;

    // Stream widths, rounded up to whole bytes.
    localparam int S_FIELDS_W = CMD_W + DATA_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = STS_W + DATA_W + CNT_OUT_W + 1 + DATA_W + DATA_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Commands; the codes above query behave as a query.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_REAR  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_QUERY      = 3'd4
    } cmd_t;

    // Result status.
    typedef enum logic [STS_W-1:0] {
        STS_OK        = 2'd0,
        STS_OVERFLOW  = 2'd1,
        STS_UNDERFLOW = 2'd2
    } status_t;

endpackage

// ===== sv/cdeq_ram.sv =====
// Slot memory of the circular deque: one write port and one read port with
// a registered read. Depends on cdeq_pkg.
module cdeq_ram #(
    parameter int DEPTH = cdeq_pkg::DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  logic [cdeq_pkg::DATA_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr,
    output logic [cdeq_pkg::DATA_W-1:0] rd_data
);
    import cdeq_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/circular_double_ended_queue_top.sv =====
// Circular double-ended queue of signed 32-bit words with a stream interface.
// Depends on cdeq_pkg, cdeq_ram and circular_double_ended_queue_top_defines.svh.
//
// Each input transaction carries a command and a word and produces exactly
// one result transaction with a status, the popped word, the entry count,
// an empty flag and the words at the front and the rear. The words live in
// a slot memory with a registered read; the front and rear words are also
// held in registers. A push, a query, a rejected command and a pop that
// empties the queue complete in the idle state. A successful pop that
// leaves words behind passes through the fetch state, as the new end word
// must be fetched through the memory read port. The input is taken
// whenever no fetch is in progress and the result register is empty or being
// drained in the same cycle. No clearing pass is needed after reset.
`include "circular_double_ended_queue_top_defines.svh"

module circular_double_ended_queue_top #(
    parameter int DEPTH = cdeq_pkg::DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Fields from bit 0: command[2:0], value[34:3], zero padding.
    input  logic [cdeq_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Fields from bit 0: status[1:0], popped_value[33:2], entry_count[38:34],
    // is_empty[39], front_value[71:40], rear_value[103:72].
    output logic [cdeq_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready
);
    import cdeq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        STATE_IDLE  = 2'b01,
        STATE_FETCH = 2'b10
    } state_t;

    // Control registers.
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [IDX_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               m_valid_reg, m_valid_next;

    // Payload registers.
    logic [DATA_W-1:0]    front_reg, front_next;
    logic [DATA_W-1:0]    rear_reg, rear_next;
    logic [DATA_W-1:0]    popped_reg, popped_next;
    logic                 fetch_front_reg, fetch_front_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    // Memory access.
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_data;

    // Decoded input and result building.
    logic              accept;
    cmd_t              cmd;
    logic [DATA_W-1:0] value;
    logic              is_full;
    logic              is_empty_now;
    logic              emit;
    status_t           emit_status;
    logic [DATA_W-1:0] emit_popped;
    logic              empty_after;
    logic [31:0]       cnt_wide;

    cdeq_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Input unpacking and handshake.
    assign cmd          = cmd_t'(s_tdata[CMD_W-1:0]);
    assign value        = s_tdata[CMD_W +: DATA_W];
    assign s_tready     = (state_reg == STATE_IDLE) && (!m_valid_reg || m_tready);
    assign accept       = s_tvalid && s_tready;
    assign is_full      = (cnt_reg == CNT_W'(DEPTH));
    assign is_empty_now = (cnt_reg == '0);

    // Command execution and result assembly.
    always_comb begin
        state_next       = state_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        cnt_next         = cnt_reg;
        front_next       = front_reg;
        rear_next        = rear_reg;
        popped_next      = popped_reg;
        fetch_front_next = fetch_front_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = value;
        rd_en            = 1'b0;
        rd_addr          = '0;
        emit             = 1'b0;
        emit_status      = STS_OK;
        emit_popped      = '0;

        // The result register drains on its own handshake.
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (state_reg == STATE_FETCH) begin
            // The new end word arrives from the memory.
            if (fetch_front_reg) begin
                front_next = rd_data;
            end else begin
                rear_next = rd_data;
            end
            emit        = 1'b1;
            emit_popped = popped_reg;
            state_next  = STATE_IDLE;
        end else if (accept) begin
            emit = 1'b1;
            case (cmd)
                CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
                    if (is_full) begin
                        emit_status = STS_OVERFLOW;
                    end else begin
                        wr_en = 1'b1;
                        if (is_empty_now) begin
                            head_next  = '0;
                            tail_next  = '0;
                            wr_addr    = '0;
                            front_next = value;
                            rear_next  = value;
                        end else if (cmd == CMD_PUSH_FRONT) begin
                            head_next  = (head_reg == '0) ? IDX_W'(DEPTH - 1)
                                                          : head_reg - 1'b1;
                            wr_addr    = head_next;
                            front_next = value;
                        end else begin
                            tail_next = (tail_reg == IDX_W'(DEPTH - 1)) ? '0
                                                                        : tail_reg + 1'b1;
                            wr_addr   = tail_next;
                            rear_next = value;
                        end
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                CMD_POP_FRONT, CMD_POP_REAR: begin
                    if (is_empty_now) begin
                        emit_status = STS_UNDERFLOW;
                    end else begin
                        emit_popped = (cmd == CMD_POP_FRONT) ? front_reg : rear_reg;
                        popped_next = emit_popped;
                        cnt_next    = cnt_reg - 1'b1;
                        if (cnt_reg == CNT_W'(1)) begin
                            // Last word gone: both indices return to slot zero.
                            head_next = '0;
                            tail_next = '0;
                        end else begin
                            // Move the index and fetch the word now at that end.
                            emit             = 1'b0;
                            rd_en            = 1'b1;
                            fetch_front_next = (cmd == CMD_POP_FRONT);
                            state_next       = STATE_FETCH;
                            if (cmd == CMD_POP_FRONT) begin
                                head_next = (head_reg == IDX_W'(DEPTH - 1)) ? '0
                                                                            : head_reg + 1'b1;
                                rd_addr   = head_next;
                            end else begin
                                tail_next = (tail_reg == '0) ? IDX_W'(DEPTH - 1)
                                                             : tail_reg - 1'b1;
                                rd_addr   = tail_next;
                            end
                        end
                    end
                end
                default: begin
                    emit_status = STS_OK;
                end
            endcase
        end

        // Pack a result from the state after the operation.
        empty_after = (cnt_next == '0);
        cnt_wide    = 32'(cnt_next);
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = M_TDATA_W'({
                empty_after ? {DATA_W{1'b0}} : rear_next,
                empty_after ? {DATA_W{1'b0}} : front_next,
                empty_after,
                cnt_wide[CNT_OUT_W-1:0],
                emit_popped,
                emit_status
            });
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= STATE_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload state.
    always_ff @(posedge aclk) begin
        front_reg       <= front_next;
        rear_reg        <= rear_next;
        popped_reg      <= popped_next;
        fetch_front_reg <= fetch_front_next;
        m_data_reg      <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Checks on the sequencing and the index bookkeeping.
    `CDEQ_ASSERT_SAME(a_fetch_out_free, state_reg == STATE_FETCH, !m_valid_reg,
        "result register occupied while a fetch completes")
    `CDEQ_ASSERT_SAME(a_empty_idx_zero, cnt_reg == '0,
        (head_reg == '0) && (tail_reg == '0), "empty queue with nonzero indices")
    `CDEQ_ASSERT_NEXT(a_underflow_rep,
        accept && is_empty_now && (cmd == CMD_POP_FRONT || cmd == CMD_POP_REAR),
        m_valid_reg && (m_data_reg[STS_W-1:0] == STS_UNDERFLOW) && (cnt_reg == '0),
        "pop from empty queue not reported as underflow")
    `CDEQ_ASSERT_NEXT(a_overflow_hold,
        accept && is_full && (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_REAR),
        $stable(cnt_reg) && $stable(head_reg) && $stable(tail_reg),
        "push onto full queue changed the queue")

endmodule
